>>> src/blm_pkg.sv
// ---------------------------------------------------------------------------
// Battery level monitor package
// Widths, register indexes, reset values and the charge curve shared by the
// battery level monitor and its divider.
// ---------------------------------------------------------------------------
package blm_pkg;

   // Group size default for the top level
   localparam int SAMPLES_DEFAULT = 9;

   // Field widths
   localparam int SAMPLE_W = 12;
   localparam int MV_W     = 13;
   localparam int PCT_W    = 7;
   localparam int TIME_W   = 32;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING   = 2'd2;

   localparam logic [MV_W-1:0]   THRESHOLD_RESET = 13'd4150;
   localparam logic [TIME_W-1:0] DEBOUNCE_RESET  = 32'd20000;
   localparam logic [TIME_W-1:0] CEILING_RESET   = 32'd1800000;

   // Charge curve: points run from full (index 0) to empty (last index)
   localparam int CURVE_POINTS = 11;
   localparam int SEG_W        = $clog2(CURVE_POINTS);

   // Interpolation divider: dividend is offset times the percent step,
   // divisor is one segment's span in millivolts
   localparam int SPAN_W = 9;
   localparam int DIV_W  = 12;

   function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
      logic [MV_W-1:0] mv;
      case (idx)
         4'd0:    mv = 13'd4200;
         4'd1:    mv = 13'd4060;
         4'd2:    mv = 13'd3980;
         4'd3:    mv = 13'd3920;
         4'd4:    mv = 13'd3870;
         4'd5:    mv = 13'd3820;
         4'd6:    mv = 13'd3790;
         4'd7:    mv = 13'd3770;
         4'd8:    mv = 13'd3730;
         4'd9:    mv = 13'd3660;
         4'd10:   mv = 13'd3300;
         default: mv = 13'd0;
      endcase
      return mv;
   endfunction

   function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_W-1:0] idx);
      logic [PCT_W-1:0] pct;
      case (idx)
         4'd0:    pct = 7'd100;
         4'd1:    pct = 7'd90;
         4'd2:    pct = 7'd80;
         4'd3:    pct = 7'd70;
         4'd4:    pct = 7'd60;
         4'd5:    pct = 7'd50;
         4'd6:    pct = 7'd40;
         4'd7:    pct = 7'd30;
         4'd8:    pct = 7'd20;
         4'd9:    pct = 7'd10;
         4'd10:   pct = 7'd0;
         default: pct = 7'd0;
      endcase
      return pct;
   endfunction

endpackage

>>> src/blm_div.sv
// ---------------------------------------------------------------------------
// Battery level monitor divider
// Restoring divider, one quotient bit per cycle, used for the charge curve
// interpolation. Pulses done in the cycle after its last step.
// ---------------------------------------------------------------------------
module blm_div import blm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [SPAN_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SPAN_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [SPAN_W-1:0] dvs_ff, dvs_in;
   logic [SPAN_W:0]   trial;
   logic              fits;

   // Shift in the next dividend bit and try the subtraction
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (run_ff) begin
         // Keep the remainder below the divisor, shift the quotient bit in
         rem_in  = fits ? SPAN_W'(trial - {1'b0, dvs_ff}) : SPAN_W'(trial);
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Hold operands
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/battery_level_monitor.sv
// ---------------------------------------------------------------------------
// Battery level monitor
// Median filter over groups of ADC samples, charge percent from a LiPo
// curve, and a debounced external power flag with a trust window.
// ---------------------------------------------------------------------------
// Each request carries one ADC sample and its millisecond timestamp. Every
// SAMPLES_PER_READING-th request closes a group and yields one response:
// twice the group's median in millivolts, the charge percent, the debounced
// external power flag and the trust flag. The median is kept by ranking each
// sample against the earlier ones of its group with a single comparator, one
// stored sample per cycle, and the input stalls while each later request
// is ranked. The closing request then passes through the median pick, the
// segment lookup and debounce update, twelve steps of the restoring divider
// and its done pulse, and the response load; the divider is skipped at the
// curve ends where no division runs, and the load waits while the previous
// response is still stalled.
// Register writes are taken at any time and should be made while the block
// is idle.
// ---------------------------------------------------------------------------
module battery_level_monitor import blm_pkg::*; #(
   parameter int SAMPLES_PER_READING = SAMPLES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_sample_mv,
   input  logic [TIME_W-1:0]     req_now_ms,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MV_W-1:0]       rsp_battery_mv,
   output logic [PCT_W-1:0]      rsp_battery_pct,
   output logic                  rsp_external_power,
   output logic                  rsp_external_trusted,
   // register port
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int N     = SAMPLES_PER_READING;
   localparam int CNT_W = $clog2(N);
   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(N - 1);
   localparam logic [CNT_W-1:0] MID_RANK = CNT_W'((N - 1) / 2);
   localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(CURVE_POINTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANK,
      ST_PICK,
      ST_SEG,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [MV_W-1:0]   thr_ff, thr_in;
   logic [TIME_W-1:0] deb_ff, deb_in;
   logic [TIME_W-1:0] ceil_ff, ceil_in;

   // group bookkeeping
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    newrank_ff, newrank_in;
   logic [SAMPLE_W-1:0] new_ff, new_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [SAMPLE_W-1:0] store_ff [N];
   logic [SAMPLE_W-1:0] store_in [N];
   logic [CNT_W-1:0]    rank_ff [N];
   logic [CNT_W-1:0]    rank_in [N];

   // reading and percent
   logic [MV_W-1:0]  mv_ff, mv_in;
   logic [PCT_W-1:0] pct_ff, pct_in;
   logic [PCT_W-1:0] base_ff, base_in;

   // external power tracking
   logic              flag_ff, flag_in;
   logic              hvalid_ff, hvalid_in;
   logic [TIME_W-1:0] hstart_ff, hstart_in;
   logic              lvalid_ff, lvalid_in;
   logic [TIME_W-1:0] lstart_ff, lstart_in;
   logic [TIME_W-1:0] since_ff, since_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]  rsp_mv_ff, rsp_mv_in;
   logic [PCT_W-1:0] rsp_pct_ff, rsp_pct_in;
   logic             rsp_ext_ff, rsp_ext_in;
   logic             rsp_trust_ff, rsp_trust_in;

   // combinational helpers
   logic                req_take;
   logic [CNT_W-1:0]    rd_idx;
   logic [SAMPLE_W-1:0] rd_data;
   logic                greater;
   logic [CNT_W-1:0]    newrank_sum;
   logic [CNT_W-1:0]    med_idx;
   logic [SEG_W-1:0]    seg;
   logic [SPAN_W-1:0]   offset;
   logic [DIV_W-1:0]    div_dividend;
   logic [SPAN_W-1:0]   div_divisor;
   logic                div_start;
   logic                div_done;
   logic [DIV_W-1:0]    div_quotient;
   logic                level_high;
   logic [TIME_W-1:0]   run_start;
   logic [TIME_W-1:0]   elapsed;
   logic [TIME_W-1:0]   flag_age;

   assign req_take = req_valid && !req_stall;

   // Find the entry ranked at the lower middle of the group
   always_comb begin
      med_idx = '0;
      for (int m = 0; m < N; m++) begin
         if (rank_ff[m] == MID_RANK) begin
            med_idx = CNT_W'(m);
         end
      end
   end

   // One read port on the sample store
   assign rd_idx      = (state_ff == ST_PICK) ? med_idx : idx_ff;
   assign rd_data     = store_ff[rd_idx];
   assign greater     = rd_data > new_ff;
   assign newrank_sum = newrank_ff + CNT_W'(!greater);

   // Pick the curve segment: the first point at or below the reading
   always_comb begin
      seg = LAST_SEG;
      for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
         if (mv_ff >= curve_mv(SEG_W'(i))) begin
            seg = SEG_W'(i);
         end
      end
   end

   assign offset       = SPAN_W'(mv_ff - curve_mv(seg));
   assign div_dividend = DIV_W'({offset, 3'b000}) + DIV_W'({offset, 1'b0});
   assign div_divisor  = SPAN_W'(curve_mv(seg - SEG_W'(1)) - curve_mv(seg));

   // Debounce timing shares one subtractor between the two runs
   assign level_high = mv_ff >= thr_ff;
   always_comb begin
      if (level_high) begin
         run_start = hvalid_ff ? hstart_ff : now_ff;
      end else begin
         run_start = lvalid_ff ? lstart_ff : now_ff;
      end
   end
   assign elapsed  = now_ff - run_start;
   assign flag_age = now_ff - since_ff;

   blm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      thr_in       = thr_ff;
      deb_in       = deb_ff;
      ceil_in      = ceil_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      newrank_in   = newrank_ff;
      new_in       = new_ff;
      now_in       = now_ff;
      store_in     = store_ff;
      rank_in      = rank_ff;
      mv_in        = mv_ff;
      pct_in       = pct_ff;
      base_in      = base_ff;
      flag_in      = flag_ff;
      hvalid_in    = hvalid_ff;
      hstart_in    = hstart_ff;
      lvalid_in    = lvalid_ff;
      lstart_in    = lstart_ff;
      since_in     = since_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mv_in    = rsp_mv_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_ext_in   = rsp_ext_ff;
      rsp_trust_in = rsp_trust_ff;
      div_start    = 1'b0;

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes
      if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD: thr_in  = csr_data[MV_W-1:0];
            CSR_DEBOUNCE:  deb_in  = csr_data[TIME_W-1:0];
            CSR_CEILING:   ceil_in = csr_data[TIME_W-1:0];
            default:       ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // Store the request and, unless it opens a group, start ranking it against the group
            if (req_take) begin
               store_in[count_ff] = req_sample_mv;
               new_in             = req_sample_mv;
               now_in             = req_now_ms;
               idx_in             = '0;
               newrank_in         = '0;
               if (count_ff == '0) begin
                  rank_in[0] = '0;
                  count_in   = CNT_W'(1);
               end else begin
                  state_in = ST_RANK;
               end
            end
         end
         ST_RANK: begin
            // Advance one stored sample per cycle
            if (greater) begin
               rank_in[idx_ff] = rank_ff[idx_ff] + CNT_W'(1);
            end
            newrank_in = newrank_sum;
            idx_in     = idx_ff + CNT_W'(1);
            if (idx_ff == count_ff - CNT_W'(1)) begin
               rank_in[count_ff] = newrank_sum;
               if (count_ff == LAST_POS) begin
                  count_in = '0;
                  state_in = ST_PICK;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PICK: begin
            mv_in    = {rd_data, 1'b0};
            state_in = ST_SEG;
         end
         ST_SEG: begin
            // Update the external power debounce
            if (level_high) begin
               lvalid_in = 1'b0;
               hvalid_in = 1'b1;
               hstart_in = run_start;
               if (!flag_ff && (elapsed > deb_ff)) begin
                  flag_in  = 1'b1;
                  since_in = now_ff;
               end
            end else begin
               hvalid_in = 1'b0;
               lvalid_in = 1'b1;
               lstart_in = run_start;
               if (flag_ff && (elapsed > deb_ff)) begin
                  flag_in = 1'b0;
               end
            end
            // Clamp at the curve ends, otherwise interpolate
            if (mv_ff >= curve_mv('0)) begin
               pct_in   = curve_pct('0);
               state_in = ST_FIN;
            end else if (mv_ff < curve_mv(LAST_SEG)) begin
               pct_in   = curve_pct(LAST_SEG);
               state_in = ST_FIN;
            end else begin
               base_in   = curve_pct(seg);
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               pct_in   = base_ff + PCT_W'(div_quotient);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Load the response once the register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_mv_in    = mv_ff;
               rsp_pct_in   = pct_ff;
               rsp_ext_in   = flag_ff;
               rsp_trust_in = flag_ff && (flag_age < ceil_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, configuration and tracking registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THRESHOLD_RESET;
         deb_ff       <= DEBOUNCE_RESET;
         ceil_ff      <= CEILING_RESET;
         count_ff     <= '0;
         flag_ff      <= 1'b0;
         hvalid_ff    <= 1'b0;
         hstart_ff    <= '0;
         lvalid_ff    <= 1'b0;
         lstart_ff    <= '0;
         since_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         deb_ff       <= deb_in;
         ceil_ff      <= ceil_in;
         count_ff     <= count_in;
         flag_ff      <= flag_in;
         hvalid_ff    <= hvalid_in;
         hstart_ff    <= hstart_in;
         lvalid_ff    <= lvalid_in;
         lstart_ff    <= lstart_in;
         since_ff     <= since_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      newrank_ff   <= newrank_in;
      new_ff       <= new_in;
      now_ff       <= now_in;
      store_ff     <= store_in;
      rank_ff      <= rank_in;
      mv_ff        <= mv_in;
      pct_ff       <= pct_in;
      base_ff      <= base_in;
      rsp_mv_ff    <= rsp_mv_in;
      rsp_pct_ff   <= rsp_pct_in;
      rsp_ext_ff   <= rsp_ext_in;
      rsp_trust_ff <= rsp_trust_in;
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_battery_mv       = rsp_mv_ff;
   assign rsp_battery_pct      = rsp_pct_ff;
   assign rsp_external_power   = rsp_ext_ff;
   assign rsp_external_trusted = rsp_trust_ff;

endmodule
